// File: sv/svds_pkg.sv
// ----------------------------------------------------------------------------
// svds_pkg: shared types and constants of the sparse vector default sum block
// Operation and result codes, command and result structs, register indexes
// and reset values.
// ----------------------------------------------------------------------------
package svds_pkg;

	localparam int ENTRIES_DEF  = 256;
	localparam int ID_WIDTH_DEF = 16;

	localparam int VALUE_W = 32;
	localparam int ELEM_W  = 16;
	localparam int LIMIT_W = 9;

	localparam logic signed [VALUE_W-1:0] SENTINEL = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic signed [VALUE_W-1:0] DEFAULT_RST = '0;
	localparam logic [LIMIT_W-1:0]        LIMIT_RST   = 9'd256;

	// configuration register indexes
	localparam logic CFG_DEFAULT = 1'b0;
	localparam logic CFG_LIMIT   = 1'b1;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_INSERT  = 2'd1,
		OP_PATTERN = 2'd2,
		OP_EXTEND  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_STATUS  = 2'd0,
		KIND_PATTERN = 2'd1,
		KIND_EXTEND  = 2'd2
	} kind_t;

	typedef struct packed {
		op_t                        operation;
		logic [ELEM_W-1:0]          element_id;
		logic signed [VALUE_W-1:0]  membership;
		logic signed [VALUE_W-1:0]  sum_in;
		logic                       last;
	} in_t;

	typedef struct packed {
		kind_t                      result_kind;
		logic signed [VALUE_W-1:0]  value;
		logic                       full_res;
		logic                       rejected;
	} out_t;

endpackage

// File: sv/sparse_vector_default_sum.sv
// ----------------------------------------------------------------------------
// sparse_vector_default_sum: sorted sparse store with default-membership sums
// Top level: configuration registers, sequencer and entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the transaction is taken at
//   a rising edge with start high and busy low. Clear empties the store,
//   insert places (element_id, membership) at its sorted position, pattern
//   steps feed increasing ids and return their membership sum on last, and
//   extension steps add the membership of each row position to sum_in (a sentinel sum_in is passed on unchanged).
//   Result channel: done is high for exactly one cycle with the result on
//   result; the receiver cannot stall, so take it in that cycle.
//   Configuration channel: cfg_ready is always high; write index 0 for the
//   default membership and index 1 for the size limit, only while idle.
// Timing:
//   Clear and rejected insert: result in the cycle right after the transaction.
//   Insert: busy while each entry with a larger id moves up one slot; the
//   walk uses the single memory read port and shared id comparator.
//   Pattern or extension step: busy while the walk pointer passes stored
//   ids below the key; the result shows in the first cycle busy is low.
// Reset: empties the store, abandons any query, default membership 0 and
//   size limit 256. Memory contents are never cleared; only entries below
//   the entry count are read.
// ----------------------------------------------------------------------------
module sparse_vector_default_sum #(
	parameter int ENTRIES  = svds_pkg::ENTRIES_DEF,
	parameter int ID_WIDTH = svds_pkg::ID_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  svds_pkg::in_t                  cmd,
	output logic                           busy,
	output logic                           done,
	output svds_pkg::out_t                 result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [svds_pkg::VALUE_W-1:0]   cfg_data
);

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ENTRY_W = ID_WIDTH + svds_pkg::VALUE_W;

	logic signed [svds_pkg::VALUE_W-1:0] default_q;
	logic [svds_pkg::LIMIT_W-1:0]        limit_q;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [IDX_W-1:0]   mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	// the user must issue configuration writes only while idle; the block does not enforce it, so always accept
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= svds_pkg::DEFAULT_RST;
			limit_q   <= svds_pkg::LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == svds_pkg::CFG_DEFAULT) begin
				default_q <= cfg_data;
			end else begin
				// keep the low bits of the size limit
				limit_q <= cfg_data[svds_pkg::LIMIT_W-1:0];
			end
		end
	end

	svds_seq #(
		.ENTRIES  (ENTRIES),
		.ID_WIDTH (ID_WIDTH)
	) u_seq (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.cmd                (cmd),
		.busy               (busy),
		.done               (done),
		.result             (result),
		.default_membership (default_q),
		.size_limit         (limit_q),
		.mem_we             (mem_we),
		.mem_waddr          (mem_waddr),
		.mem_wdata          (mem_wdata),
		.mem_raddr          (mem_raddr),
		.mem_rdata          (mem_rdata)
	);

	svds_store #(
		.ENTRIES  (ENTRIES),
		.ID_WIDTH (ID_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef SYNTHESIS
	// a clear always answers in the next cycle with a plain status
	a_clear_status: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.operation == svds_pkg::OP_CLEAR |=>
		done && result.result_kind == svds_pkg::KIND_STATUS && !result.rejected &&
		result.value == '0)
		else $error("clear did not return a status result in the next cycle");

	// only a status result may carry the reject flag
	a_reject_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.rejected |-> result.result_kind == svds_pkg::KIND_STATUS)
		else $error("reject flag on a query result");

	// a query step always walks the store, so the block stays busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.operation == svds_pkg::OP_PATTERN ||
		cmd.operation == svds_pkg::OP_EXTEND) |=> busy && !done)
		else $error("query step finished without walking the store");
`endif

endmodule

// File: sv/svds_store.sv
// ----------------------------------------------------------------------------
// svds_store: entry memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module svds_store #(
	parameter int ENTRIES  = svds_pkg::ENTRIES_DEF,
	parameter int ID_WIDTH = svds_pkg::ID_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] waddr,
	input  logic [ID_WIDTH+svds_pkg::VALUE_W-1:0] wdata,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] raddr,
	output logic [ID_WIDTH+svds_pkg::VALUE_W-1:0] rdata
);

	localparam int ENTRY_W = ID_WIDTH + svds_pkg::VALUE_W;

	logic [ENTRY_W-1:0] mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/svds_seq.sv
// ----------------------------------------------------------------------------
// svds_seq: command sequencer
// Walks the sorted store with one shared id comparator and one shared adder,
// shifts entries for sorted insert, and registers the result strobe.
// ----------------------------------------------------------------------------
module svds_seq #(
	parameter int ENTRIES  = svds_pkg::ENTRIES_DEF,
	parameter int ID_WIDTH = svds_pkg::ID_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  svds_pkg::in_t                          cmd,
	output logic                                   busy,
	output logic                                   done,
	output svds_pkg::out_t                         result,
	input  logic signed [svds_pkg::VALUE_W-1:0]    default_membership,
	input  logic [svds_pkg::LIMIT_W-1:0]           size_limit,
	output logic                                   mem_we,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] mem_waddr,
	output logic [ID_WIDTH+svds_pkg::VALUE_W-1:0]  mem_wdata,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] mem_raddr,
	input  logic [ID_WIDTH+svds_pkg::VALUE_W-1:0]  mem_rdata
);

	localparam int VW    = svds_pkg::VALUE_W;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > svds_pkg::LIMIT_W) ? CNT_W : svds_pkg::LIMIT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LSCAN,
		S_LCMP,
		S_LAPPLY,
		S_ISCAN,
		S_ICMP
	} state_t;

	state_t                  state_q;
	svds_pkg::op_t           op_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        wp_q;
	logic [CNT_W-1:0]        pos_q;
	logic [ID_WIDTH-1:0]     rp_q;
	logic [ID_WIDTH-1:0]     key_q;
	logic signed [VW-1:0]    rs_q;
	logic signed [VW-1:0]    memb_q;
	logic signed [VW-1:0]    acc_q;
	logic signed [VW-1:0]    m_q;
	logic                    last_q;
	logic                    done_q;
	svds_pkg::out_t          res_q;

	logic [ID_WIDTH-1:0]     rd_id;
	logic signed [VW-1:0]    rd_memb;
	logic [ID_WIDTH-1:0]     id_in;
	logic [CNT_W-1:0]        cnt_inc;
	logic [CNT_W-1:0]        pos_dec;
	logic                    id_lt;
	logic                    id_eq;
	logic signed [VW-1:0]    add_a;
	logic signed [VW-1:0]    add_sum;
	logic                    reject;
	logic                    full_now;
	logic                    full_inc;
	logic                    full_zero;

	assign rd_id   = mem_rdata[ID_WIDTH+VW-1:VW];
	assign rd_memb = mem_rdata[VW-1:0];
	assign id_in   = ID_WIDTH'(cmd.element_id);
	assign cnt_inc = cnt_q + 1'b1;
	assign pos_dec = pos_q - 1'b1;

	// shared comparator: stored id against the key
	assign id_lt = rd_id < key_q;
	assign id_eq = rd_id == key_q;

	// shared adder: running sum for patterns, accumulator for rows
	assign add_a   = (op_q == svds_pkg::OP_PATTERN) ? rs_q : acc_q;
	assign add_sum = add_a + m_q;

	assign reject    = (CMP_W'(cnt_q) >= CMP_W'(size_limit)) ||
	                   (CMP_W'(cnt_q) >= CMP_W'(ENTRIES));
	assign full_now  = CMP_W'(cnt_q) == CMP_W'(size_limit);
	assign full_inc  = CMP_W'(cnt_inc) == CMP_W'(size_limit);
	assign full_zero = size_limit == '0;

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[IDX_W-1:0];
		mem_wdata = {key_q, memb_q};
		mem_raddr = (state_q == S_ISCAN) ? pos_dec[IDX_W-1:0] : wp_q[IDX_W-1:0];
		case (state_q)
			S_ISCAN: begin
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end
			end
			S_ICMP: begin
				mem_we = 1'b1;
				if (!id_lt && !id_eq) begin
					mem_wdata = mem_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= svds_pkg::OP_CLEAR;
			cnt_q   <= '0;
			wp_q    <= '0;
			pos_q   <= '0;
			rp_q    <= '0;
			key_q   <= '0;
			rs_q    <= '0;
			memb_q  <= '0;
			acc_q   <= '0;
			m_q     <= '0;
			last_q  <= 1'b0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q   <= cmd.operation;
						key_q  <= (cmd.operation == svds_pkg::OP_EXTEND) ? rp_q : id_in;
						memb_q <= cmd.membership;
						acc_q  <= cmd.sum_in;
						last_q <= cmd.last;
						res_q.result_kind <= svds_pkg::KIND_STATUS;
						res_q.value       <= '0;
						res_q.rejected    <= 1'b0;
						case (cmd.operation)
							svds_pkg::OP_CLEAR: begin
								cnt_q <= '0;
								wp_q  <= '0;
								rs_q  <= '0;
								rp_q  <= '0;
								done_q <= 1'b1;
								res_q.full_res <= full_zero;
							end
							svds_pkg::OP_INSERT: begin
								wp_q <= '0;
								rs_q <= '0;
								rp_q <= '0;
								if (reject) begin
									done_q <= 1'b1;
									res_q.full_res <= full_now;
									res_q.rejected <= 1'b1;
								end else begin
									pos_q   <= cnt_q;
									state_q <= S_ISCAN;
								end
							end
							default: begin
								state_q <= S_LSCAN;
							end
						endcase
					end
				end
				S_LSCAN: begin
					if (wp_q >= cnt_q) begin
						m_q     <= default_membership;
						state_q <= S_LAPPLY;
					end else begin
						state_q <= S_LCMP;
					end
				end
				S_LCMP: begin
					if (id_lt) begin
						wp_q    <= wp_q + 1'b1;
						state_q <= S_LSCAN;
					end else begin
						m_q     <= id_eq ? rd_memb : default_membership;
						state_q <= S_LAPPLY;
					end
				end
				S_LAPPLY: begin
					state_q <= S_IDLE;
					res_q.full_res <= full_now;
					res_q.rejected <= 1'b0;
					if (op_q == svds_pkg::OP_PATTERN) begin
						res_q.result_kind <= svds_pkg::KIND_PATTERN;
						res_q.value       <= add_sum;
						if (last_q) begin
							done_q <= 1'b1;
							rs_q   <= '0;
							wp_q   <= '0;
						end else begin
							rs_q <= add_sum;
						end
					end else begin
						done_q <= 1'b1;
						res_q.result_kind <= svds_pkg::KIND_EXTEND;
						res_q.value <= (acc_q == svds_pkg::SENTINEL) ? acc_q : add_sum;
						if (last_q) begin
							rp_q <= '0;
							wp_q <= '0;
						end else begin
							rp_q <= rp_q + 1'b1;
						end
					end
				end
				S_ISCAN: begin
					if (pos_q == '0) begin
						cnt_q   <= cnt_inc;
						done_q  <= 1'b1;
						res_q.full_res <= full_inc;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ICMP;
					end
				end
				S_ICMP: begin
					if (!id_lt && !id_eq) begin
						// stored id is larger: move it up one slot
						pos_q   <= pos_dec;
						state_q <= S_ISCAN;
					end else begin
						cnt_q   <= cnt_inc;
						done_q  <= 1'b1;
						res_q.full_res <= full_inc;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
